// File: src/bpt_pkg.sv
// Shared types and constants for the bidirectional position trigger.
`timescale 1ns / 1ps
`default_nettype none
package bpt_pkg;

	// Default encoder sample width
	localparam int PositionBitsDef = 16;

	// Configuration register widths and indexes
	localparam int CfgBits   = 16;
	localparam int CfgIdxBits = 3;
	localparam logic [CfgIdxBits-1:0] REG_LOW_BOUND   = 3'd0;
	localparam logic [CfgIdxBits-1:0] REG_HIGH_BOUND  = 3'd1;
	localparam logic [CfgIdxBits-1:0] REG_STEP_SIZE   = 3'd2;
	localparam logic [CfgIdxBits-1:0] REG_SWEEP_TOTAL = 3'd3;

	// Result field widths
	localparam int CountBits = 32;
	localparam int SweepBits = 16;
	localparam int PhaseBits = 3;
	localparam int PointBits = 18;

	// Result tdata: level, fired, count, sweeps, phase, padded to bytes
	localparam int ResBits   = 2 + CountBits + SweepBits + PhaseBits;
	localparam int ResTdataW = ((ResBits + 7) / 8) * 8;

	// Reported phase codes
	localparam logic [PhaseBits-1:0] PHASE_IDLE      = 3'd0;
	localparam logic [PhaseBits-1:0] PHASE_UP        = 3'd1;
	localparam logic [PhaseBits-1:0] PHASE_WAIT_HIGH = 3'd2;
	localparam logic [PhaseBits-1:0] PHASE_DOWN      = 3'd3;
	localparam logic [PhaseBits-1:0] PHASE_WAIT_LOW  = 3'd4;

	// Configuration register set
	typedef struct packed {
		logic [CfgBits-1:0] low_bound;
		logic [CfgBits-1:0] high_bound;
		logic [CfgBits-1:0] step_size;
		logic [CfgBits-1:0] sweep_total;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic                 trigger_level;
		logic                 trigger_fired;
		logic [CountBits-1:0] trigger_count;
		logic [SweepBits-1:0] sweeps_done;
		logic [PhaseBits-1:0] phase_code;
		logic                 finished;
	} result_t;

endpackage
`default_nettype wire

// File: src/bpt_cfg_regs.sv
// Configuration register file of the position trigger.
`timescale 1ns / 1ps
`default_nettype none
module bpt_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bpt_pkg::CfgIdxBits-1:0] cfg_index,
	input  wire logic [bpt_pkg::CfgBits-1:0]    cfg_data,
	output bpt_pkg::cfg_t                       cfg
);

	bpt_pkg::cfg_t cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_bound   <= '0;
			cfg_q.high_bound  <= '0;
			cfg_q.step_size   <= bpt_pkg::CfgBits'(1);
			cfg_q.sweep_total <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bpt_pkg::REG_LOW_BOUND:   cfg_q.low_bound   <= cfg_data;
				bpt_pkg::REG_HIGH_BOUND:  cfg_q.high_bound  <= cfg_data;
				bpt_pkg::REG_STEP_SIZE:   cfg_q.step_size   <= cfg_data;
				bpt_pkg::REG_SWEEP_TOTAL: cfg_q.sweep_total <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: src/bpt_core.sv
// Sweep state machine, trigger logic and result register.
`timescale 1ns / 1ps
`default_nettype none
module bpt_core #(
	parameter int POSITION_BITS = bpt_pkg::PositionBitsDef
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire bpt_pkg::cfg_t            cfg,
	input  wire logic                     item_valid,
	input  wire logic                     item_start,
	input  wire logic [POSITION_BITS-1:0] item_position,
	output logic                          item_ready,
	output logic                          res_valid,
	input  wire logic                     res_ready,
	output bpt_pkg::result_t              res
);

	// Compare width: covers the sample and bound plus or minus twice the step
	localparam int CmpBits = ((POSITION_BITS > 19) ? POSITION_BITS : 19) + 1;
	localparam int PB = bpt_pkg::PointBits;
	localparam int CB = bpt_pkg::CfgBits;

	typedef enum logic [bpt_pkg::PhaseBits-1:0] {
		ST_IDLE      = bpt_pkg::PHASE_IDLE,
		ST_UP        = bpt_pkg::PHASE_UP,
		ST_WAIT_HIGH = bpt_pkg::PHASE_WAIT_HIGH,
		ST_DOWN      = bpt_pkg::PHASE_DOWN,
		ST_WAIT_LOW  = bpt_pkg::PHASE_WAIT_LOW
	} phase_t;

	phase_t                           phase_q, phase_n;
	logic signed [PB-1:0]             point_q, point_n;
	logic [bpt_pkg::SweepBits-1:0]    sweep_q, sweep_n, sweep_inc;
	logic [bpt_pkg::CountBits-1:0]    count_q, count_n;
	logic                             level_q, level_n;
	logic                             fired, done;

	logic                             res_valid_q;
	bpt_pkg::result_t                 res_q;

	logic signed [CmpBits-1:0] pos_x, pt_x, pt_a, lo_x, hi_x, st_x, hi_turn, lo_turn;
	logic                      hit, past_end;

	// Take an item whenever the result register is free or being emptied
	assign item_ready = !res_valid_q || res_ready;

	// Widen operands to the common signed compare width
	always_comb begin
		pos_x   = CmpBits'(signed'(item_position));
		pt_x    = CmpBits'(point_q);
		lo_x    = signed'(CmpBits'({1'b0, cfg.low_bound}));
		hi_x    = signed'(CmpBits'({1'b0, cfg.high_bound}));
		st_x    = signed'(CmpBits'({1'b0, cfg.step_size}));
		hi_turn = hi_x + (st_x <<< 1);
		lo_turn = lo_x - (st_x <<< 1);
		sweep_inc = sweep_q + 1'b1;
	end

	// Next state for one item
	always_comb begin
		phase_n  = phase_q;
		point_n  = point_q;
		sweep_n  = sweep_q;
		count_n  = count_q;
		level_n  = level_q;
		fired    = 1'b0;
		done     = 1'b0;
		hit      = 1'b0;
		past_end = 1'b0;
		pt_a     = pt_x;
		if (item_start) begin
			count_n = '0;
			sweep_n = '0;
			point_n = PB'({1'b0, cfg.low_bound});
			if (cfg.sweep_total == '0) begin
				phase_n = ST_IDLE;
				done    = 1'b1;
			end else begin
				phase_n = ST_UP;
			end
		end else begin
			case (phase_q)
				ST_UP: begin
					hit      = pos_x >= pt_x;
					pt_a     = hit ? pt_x + st_x : pt_x;
					past_end = pt_a > hi_x;
					point_n  = PB'(pt_a);
					if (past_end) begin
						point_n = PB'({1'b0, cfg.high_bound});
						sweep_n = sweep_inc;
						if (sweep_inc >= cfg.sweep_total) begin
							phase_n = ST_IDLE;
							done    = 1'b1;
						end else begin
							phase_n = (pos_x >= hi_turn) ? ST_DOWN : ST_WAIT_HIGH;
						end
					end
				end
				ST_WAIT_HIGH: begin
					if (pos_x >= hi_turn) phase_n = ST_DOWN;
				end
				ST_DOWN: begin
					hit      = pos_x <= pt_x;
					pt_a     = hit ? pt_x - st_x : pt_x;
					past_end = pt_a < lo_x;
					point_n  = PB'(pt_a);
					if (past_end) begin
						point_n = PB'({1'b0, cfg.low_bound});
						sweep_n = sweep_inc;
						if (sweep_inc >= cfg.sweep_total) begin
							phase_n = ST_IDLE;
							done    = 1'b1;
						end else begin
							phase_n = (pos_x <= lo_turn) ? ST_UP : ST_WAIT_LOW;
						end
					end
				end
				ST_WAIT_LOW: begin
					if (pos_x <= lo_turn) phase_n = ST_UP;
				end
				default: phase_n = ST_IDLE;
			endcase
			if (hit) begin
				fired   = 1'b1;
				level_n = !level_q;
				count_n = count_q + 1'b1;
			end
		end
	end

	// Advance state and load the result on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ST_IDLE;
			point_q     <= '0;
			sweep_q     <= '0;
			count_q     <= '0;
			level_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				phase_q     <= phase_n;
				point_q     <= point_n;
				sweep_q     <= sweep_n;
				count_q     <= count_n;
				level_q     <= level_n;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			res_q.trigger_level <= level_n;
			res_q.trigger_fired <= fired;
			res_q.trigger_count <= count_n;
			res_q.sweeps_done   <= sweep_n;
			res_q.phase_code    <= phase_n;
			res_q.finished      <= done;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Width of the unsigned config operand is fixed by the package
	if (CB + 2 > CmpBits) begin : g_width_check
		$error("compare width too narrow");
	end

endmodule
`default_nettype wire

// File: src/bpt_in_stage.sv
// Input register stage: holds one accepted item ahead of the core.
`timescale 1ns / 1ps
`default_nettype none
module bpt_in_stage #(
	parameter int POSITION_BITS = bpt_pkg::PositionBitsDef
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic                     in_start,
	input  wire logic [POSITION_BITS-1:0] in_position,
	output logic                          in_ready,
	output logic                          out_valid,
	output logic                          out_start,
	output logic [POSITION_BITS-1:0]      out_position,
	input  wire logic                     out_ready
);

	logic                     valid_s1;
	logic                     start_s1;
	logic [POSITION_BITS-1:0] position_s1;

	// Accept when empty or when the held item moves on
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the payload of the accepted item
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			start_s1    <= in_start;
			position_s1 <= in_position;
		end
	end

	assign out_valid    = valid_s1;
	assign out_start    = start_s1;
	assign out_position = position_s1;

endmodule
`default_nettype wire

// File: src/bidirectional_position_trigger.sv
// Top level of the bidirectional position trigger.
`timescale 1ns / 1ps
`default_nettype none
// Toggles a trigger line at equally spaced encoder positions while a stage
// sweeps back and forth. A start item (tuser high) clears the counts and arms
// an upward sweep at low_bound; samples (tuser low) then toggle the line each
// time the position crosses the next point. Each item yields exactly one
// result item. An item passes an input register and then the state update
// into the result register. One item per cycle is sustained while the
// result side does not stall; the state update in the core sets that rate,
// since each item reads the state the previous one left.
module bidirectional_position_trigger #(
	parameter int POSITION_BITS = bpt_pkg::PositionBitsDef
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration write port
	input  wire logic                              cfg_we,
	input  wire logic [bpt_pkg::CfgIdxBits-1:0]    cfg_index,
	input  wire logic [bpt_pkg::CfgBits-1:0]       cfg_data,
	// Input items
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// position
	input  wire logic [((POSITION_BITS+7)/8)*8-1:0] s_tdata,
	// operation (0 sample, 1 start)
	input  wire logic                              s_tuser,
	// Result items
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// trigger_level, trigger_fired, trigger_count, sweeps_done, phase_code
	output logic [bpt_pkg::ResTdataW-1:0]          m_tdata,
	// finished
	output logic                                   m_tlast
);

	bpt_pkg::cfg_t            cfg;
	bpt_pkg::result_t         res;
	logic                     st_valid, st_start, st_ready;
	logic [POSITION_BITS-1:0] st_position;

	bpt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bpt_in_stage #(.POSITION_BITS(POSITION_BITS)) u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_start     (s_tuser),
		.in_position  (s_tdata[POSITION_BITS-1:0]),
		.in_ready     (s_tready),
		.out_valid    (st_valid),
		.out_start    (st_start),
		.out_position (st_position),
		.out_ready    (st_ready)
	);

	bpt_core #(.POSITION_BITS(POSITION_BITS)) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.item_valid    (st_valid),
		.item_start    (st_start),
		.item_position (st_position),
		.item_ready    (st_ready),
		.res_valid     (m_tvalid),
		.res_ready     (m_tready),
		.res           (res)
	);

	// Pack the result fields, lowest first
	assign m_tdata = bpt_pkg::ResTdataW'({res.phase_code, res.sweeps_done,
		res.trigger_count, res.trigger_fired, res.trigger_level});
	assign m_tlast = res.finished;

	// An empty result register never stalls the input side
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// A finishing item leaves the block idle
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> res.phase_code == bpt_pkg::PHASE_IDLE)
		else $error("finished result without idle phase");

	// A fired item that reports the low wait phase has completed a sweep
	a_fire_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.trigger_fired |->
			res.phase_code != bpt_pkg::PHASE_WAIT_LOW || res.sweeps_done != '0)
		else $error("toggle reported before any sweep completed in wait phase");

endmodule
`default_nettype wire

// File: dv/bpt_tb_pkg.sv
// Testbench types and constants shared by the trigger checker and the testbench top.
`timescale 1ns / 1ps
package bpt_tb_pkg;

	// Item kinds carried on s_tuser
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_START  = 1'b1
	} op_e;

	// Overtravel past a bound, in steps, that turns the stage around
	localparam int OvertravelSteps = 2;

	// Encoder sample width and its byte-padded tdata width
	localparam int PosBits   = bpt_pkg::PositionBitsDef;
	localparam int PosTdataW = ((PosBits + 7) / 8) * 8;
	localparam int PosMax    = 2 ** (PosBits - 1) - 1;
	localparam int PosMin    = -(2 ** (PosBits - 1));

endpackage

// File: dv/bpt_checker.sv
// Checker that tracks the trigger sweep state from accepted items and compares every result item.
`timescale 1ns / 1ps
module bpt_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bpt_pkg::CfgIdxBits-1:0]      cfg_index,
	input  logic [bpt_pkg::CfgBits-1:0]         cfg_data,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	// position
	input  logic [bpt_tb_pkg::PosTdataW-1:0]    s_tdata,
	// operation (0 sample, 1 start)
	input  logic                                s_tuser,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	// trigger_level, trigger_fired, trigger_count, sweeps_done, phase_code
	input  logic [bpt_pkg::ResTdataW-1:0]       m_tdata,
	// finished
	input  logic                                m_tlast,
	output int                                  mismatches,
	output int                                  outstanding,
	output int                                  checked,
	output int                                  toggles_seen,
	output int                                  scans_finished,
	output logic                                scan_idle
);
	import bpt_pkg::*;
	import bpt_tb_pkg::*;

	// Register copies
	logic [CfgBits-1:0] low_bound, high_bound, step_size, sweep_total;

	// Sweep state
	logic [PhaseBits-1:0]        sweep_phase;
	logic signed [PointBits-1:0] sweep_point;
	logic [SweepBits-1:0]        sweep_tally;
	logic [CountBits-1:0]        toggle_total;
	logic                        line_level;

	// Reports owed by the DUT, oldest first
	result_t trigger_reports[$];

	int mismatch_total, checked_total, fired_total, finish_total;

	function automatic string describe(result_t r);
		return $sformatf("level %0b fired %0b count %0d sweeps %0d phase %0d finished %0b",
			r.trigger_level, r.trigger_fired, r.trigger_count, r.sweeps_done,
			r.phase_code, r.finished);
	endfunction

	// Advance the sweep by one item and form the report it causes
	task automatic advance_sweep(input op_e op, input logic signed [PosBits-1:0] raw,
			output result_t r);
		int   pos, pt, lo, hi, st;
		logic fired, done;
		pos   = int'(raw);
		pt    = int'(sweep_point);
		lo    = int'(low_bound);
		hi    = int'(high_bound);
		st    = int'(step_size);
		fired = 1'b0;
		done  = 1'b0;
		if (op == OP_START) begin
			// Clear counts and arm an upward sweep, or finish at once if no sweeps are set; the line level is kept
			toggle_total = '0;
			sweep_tally  = '0;
			pt           = lo;
			if (sweep_total == '0) begin
				sweep_phase = PHASE_IDLE;
				done        = 1'b1;
			end else begin
				sweep_phase = PHASE_UP;
			end
		end else begin
			case (sweep_phase)
				PHASE_UP: begin
					if (pos >= pt) begin
						line_level   = ~line_level;
						toggle_total = toggle_total + 1'b1;
						fired        = 1'b1;
						pt           = pt + st;
					end
					// Sweep ends once the point passes the far bound
					if (pt > hi) begin
						pt          = hi;
						sweep_tally = sweep_tally + 1'b1;
						if (sweep_tally >= sweep_total) begin
							sweep_phase = PHASE_IDLE;
							done        = 1'b1;
						end else if (pos >= hi + OvertravelSteps * st) begin
							sweep_phase = PHASE_DOWN;
						end else begin
							sweep_phase = PHASE_WAIT_HIGH;
						end
					end
				end
				PHASE_WAIT_HIGH: begin
					if (pos >= hi + OvertravelSteps * st)
						sweep_phase = PHASE_DOWN;
				end
				PHASE_DOWN: begin
					if (pos <= pt) begin
						line_level   = ~line_level;
						toggle_total = toggle_total + 1'b1;
						fired        = 1'b1;
						pt           = pt - st;
					end
					if (pt < lo) begin
						pt          = lo;
						sweep_tally = sweep_tally + 1'b1;
						if (sweep_tally >= sweep_total) begin
							sweep_phase = PHASE_IDLE;
							done        = 1'b1;
						end else if (pos <= lo - OvertravelSteps * st) begin
							sweep_phase = PHASE_UP;
						end else begin
							sweep_phase = PHASE_WAIT_LOW;
						end
					end
				end
				PHASE_WAIT_LOW: begin
					if (pos <= lo - OvertravelSteps * st)
						sweep_phase = PHASE_UP;
				end
				// Idle ignores samples
				default: sweep_phase = PHASE_IDLE;
			endcase
		end
		sweep_point     = pt[PointBits-1:0];
		r.trigger_level = line_level;
		r.trigger_fired = fired;
		r.trigger_count = toggle_total;
		r.sweeps_done   = sweep_tally;
		r.phase_code    = sweep_phase;
		r.finished      = done;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want, got;
		if (!arst_n) begin
			low_bound      = '0;
			high_bound     = '0;
			step_size      = CfgBits'(1);
			sweep_total    = '0;
			sweep_phase    = PHASE_IDLE;
			sweep_point    = '0;
			sweep_tally    = '0;
			toggle_total   = '0;
			line_level     = 1'b0;
			mismatch_total = 0;
			checked_total  = 0;
			fired_total    = 0;
			finish_total   = 0;
			trigger_reports.delete();
			mismatches     <= 0;
			outstanding    <= 0;
			checked        <= 0;
			toggles_seen   <= 0;
			scans_finished <= 0;
			scan_idle      <= 1'b1;
		end else begin
			// Track register writes; unused indexes are dropped
			if (cfg_we) begin
				case (cfg_index)
					REG_LOW_BOUND:   low_bound   = cfg_data;
					REG_HIGH_BOUND:  high_bound  = cfg_data;
					REG_STEP_SIZE:   step_size   = cfg_data;
					REG_SWEEP_TOTAL: sweep_total = cfg_data;
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				advance_sweep(op_e'(s_tuser), s_tdata[PosBits-1:0], want);
				trigger_reports.push_back(want);
			end

			// Compare each result item with the oldest report owed
			if (m_tvalid && m_tready) begin
				got.trigger_level = m_tdata[0];
				got.trigger_fired = m_tdata[1];
				got.trigger_count = m_tdata[2 +: CountBits];
				got.sweeps_done   = m_tdata[2 + CountBits +: SweepBits];
				got.phase_code    = m_tdata[2 + CountBits + SweepBits +: PhaseBits];
				got.finished      = m_tlast;
				if (trigger_reports.size() == 0) begin
					if (mismatch_total < 10)
						$display("result %0d arrived with nothing owed: %s",
							checked_total, describe(got));
					mismatch_total++;
				end else begin
					want = trigger_reports.pop_front();
					if (got !== want) begin
						if (mismatch_total < 10) begin
							$display("result %0d mismatch", checked_total);
							$display("  expected %s", describe(want));
							$display("  actual   %s", describe(got));
						end
						mismatch_total++;
					end
					if (want.trigger_fired)
						fired_total++;
					if (want.finished)
						finish_total++;
				end
				checked_total++;
			end

			mismatches     <= mismatch_total;
			outstanding    <= trigger_reports.size();
			checked        <= checked_total;
			toggles_seen   <= fired_total;
			scans_finished <= finish_total;
			scan_idle      <= (sweep_phase == PHASE_IDLE);
		end
	end

endmodule

// File: dv/bidirectional_position_trigger_tb.sv
// Testbench top: drives configuration and position items into the trigger and gives the verdict.
`timescale 1ns / 1ps
module bidirectional_position_trigger_tb;
	import bpt_pkg::*;
	import bpt_tb_pkg::*;

	localparam int RandomItems   = 1900;
	localparam int DirectedItems = 23;
	localparam int WatchdogLimit = 2000;
	localparam int DrainCycles   = 8;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CfgIdxBits-1:0] cfg_index = REG_LOW_BOUND;
	logic [CfgBits-1:0]    cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [PosTdataW-1:0]  s_tdata   = '0;
	logic                  s_tuser   = OP_SAMPLE;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [ResTdataW-1:0]  m_tdata;
	logic                  m_tlast;

	int   mismatches, outstanding, checked, toggles_seen, scans_finished;
	logic scan_idle;

	int sender_idle_pct = 0;
	int stall_pct       = 0;
	int items_sent      = 0;
	int scans_run       = 0;
	int quiet_cycles    = 0;

	// Register values as last written, used to steer the stage motion
	int lo_set   = 0;
	int hi_set   = 0;
	int step_set = 1;

	bidirectional_position_trigger dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	bpt_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.checked        (checked),
		.toggles_seen   (toggles_seen),
		.scans_finished (scans_finished),
		.scan_idle      (scan_idle)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("watchdog: no item moved for %0d cycles", WatchdogLimit);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Offer one item, after a random gap, and hold it until accepted
	task automatic send_item(input op_e op, input logic [PosBits-1:0] pos);
		if ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= PosTdataW'(pos);
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Hold off the sender until every owed result has come out
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Write all four registers back to back, then one unused index
	task automatic write_config(input logic [CfgBits-1:0] lo, input logic [CfgBits-1:0] hi,
			input logic [CfgBits-1:0] st, input logic [CfgBits-1:0] tot);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LOW_BOUND;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_HIGH_BOUND;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_index <= REG_STEP_SIZE;
		cfg_data  <= st;
		@(posedge clk);
		cfg_index <= REG_SWEEP_TOTAL;
		cfg_data  <= tot;
		@(posedge clk);
		cfg_index <= REG_SWEEP_TOTAL + CfgIdxBits'($urandom_range(1, 4));
		cfg_data  <= CfgBits'($urandom);
		@(posedge clk);
		cfg_we   <= 1'b0;
		lo_set   = int'(lo);
		hi_set   = int'(hi);
		step_set = int'(st);
	endtask

	// Choose a scan setting: mostly small ranges, some extremes and odd cases
	task automatic pick_config();
		int lo, hi, st, tot;
		case ($urandom_range(9))
			7: begin
				lo  = $urandom_range(1) ? 65535 : 0;
				hi  = $urandom_range(65535);
				st  = $urandom_range(2);
				st  = (st == 2) ? 65535 : st;
				tot = $urandom_range(1) ? 65535 : 0;
			end
			8: begin
				// low bound above high bound
				hi  = $urandom_range(0, 500);
				lo  = hi + $urandom_range(1, 300);
				st  = $urandom_range(0, 40);
				tot = $urandom_range(1, 5);
			end
			9: begin
				// point never moves
				lo  = $urandom_range(0, 500);
				hi  = lo + $urandom_range(0, 200);
				st  = 0;
				tot = $urandom_range(1, 4);
			end
			default: begin
				lo  = $urandom_range(0, 3000);
				st  = $urandom_range(1, 60);
				hi  = lo + st * $urandom_range(0, 10) + $urandom_range(0, st);
				tot = $urandom_range(1, 6);
			end
		endcase
		write_config(CfgBits'(lo), CfgBits'(hi), CfgBits'(st), CfgBits'(tot));
	endtask

	// Start a scan and move the stage back and forth past the bounds
	task automatic run_scan();
		int pos, dir, speed, margin, span, k, pick;
		send_item(OP_START, PosBits'($urandom));
		pos    = lo_set - int'($urandom_range(0, 4));
		dir    = 1;
		margin = $urandom_range(0, 3);
		span   = $urandom_range(60, 250);
		for (k = 0; k < span; k++) begin
			if (k > 1 && scan_idle)
				break;
			pick = $urandom_range(99);
			if (pick < 2) begin
				send_item(OP_START, PosBits'($urandom));
			end else if (pick < 10) begin
				send_item(OP_SAMPLE, PosBits'($urandom));
			end else begin
				speed = $urandom_range(0, (step_set == 0) ? 6 :
					((step_set > 2000) ? 4000 : step_set + 2));
				pos = pos + dir * speed;
				// Turn around past the overtravel point or at the encoder limits
				if (pos >= PosMax) begin
					pos = PosMax;
					dir = -1;
				end else if (pos <= PosMin) begin
					pos = PosMin;
					dir = 1;
				end else if (dir > 0 && pos > hi_set + OvertravelSteps * step_set + margin) begin
					dir    = -1;
					margin = $urandom_range(0, 3);
				end else if (dir < 0 && pos < lo_set - OvertravelSteps * step_set - margin) begin
					dir    = 1;
					margin = $urandom_range(0, 3);
				end
				send_item(OP_SAMPLE, PosBits'(pos));
			end
		end
		scans_run++;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Samples while idle are ignored; a start with zero sweeps finishes at once
		send_item(OP_SAMPLE, PosBits'(PosMin));
		send_item(OP_SAMPLE, PosBits'(PosMax));
		send_item(OP_START, PosBits'(-1));

		// Three sweeps over a small range
		wait_for_results();
		write_config(CfgBits'(10), CfgBits'(20), CfgBits'(5), CfgBits'(3));
		send_item(OP_START, PosBits'(0));
		send_item(OP_SAMPLE, PosBits'(9));
		send_item(OP_SAMPLE, PosBits'(PosMax));
		send_item(OP_SAMPLE, PosBits'(15));
		// end of upward sweep without overtravel, then turn
		send_item(OP_SAMPLE, PosBits'(20));
		send_item(OP_SAMPLE, PosBits'(30));
		send_item(OP_SAMPLE, PosBits'(PosMin));
		send_item(OP_SAMPLE, PosBits'(15));
		// end of downward sweep with overtravel already shown
		send_item(OP_SAMPLE, PosBits'(0));
		send_item(OP_SAMPLE, PosBits'(10));
		send_item(OP_SAMPLE, PosBits'(15));
		// last sweep finishes without waiting for overtravel
		send_item(OP_SAMPLE, PosBits'(21));
		send_item(OP_SAMPLE, PosBits'(100));
		// restart while running
		send_item(OP_START, PosBits'(0));
		send_item(OP_SAMPLE, PosBits'(12));
		send_item(OP_START, PosBits'(0));

		// Low bound above high bound with a zero step
		wait_for_results();
		write_config(CfgBits'(300), CfgBits'(200), CfgBits'(0), CfgBits'(2));
		send_item(OP_START, PosBits'(0));
		send_item(OP_SAMPLE, PosBits'(0));
		send_item(OP_SAMPLE, PosBits'(200));
		send_item(OP_SAMPLE, PosBits'(250));

		// Random scans, rotating through the idling modes
		while (items_sent < DirectedItems + RandomItems) begin
			case (scans_run % 4)
				0: begin
					sender_idle_pct = 0;
					stall_pct       = 0;
				end
				1: begin
					sender_idle_pct = 57;
					stall_pct       = 0;
				end
				2: begin
					sender_idle_pct = 0;
					stall_pct       = 57;
				end
				default: begin
					sender_idle_pct = 9;
					stall_pct       = 9;
				end
			endcase
			wait_for_results();
			pick_config();
			run_scan();
		end

		wait_for_results();
		$display("Sent %0d items over %0d random scans; checked %0d results,",
			items_sent, scans_run, checked);
		$display("seeing %0d trigger toggles and %0d completed scans.",
			toggles_seen, scans_finished);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
